### rtl/assert_macros.svh
// Assertion macros used by the checker in occb_checker.sv.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define OCCB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Non-overlapping implication: the consequent holds in the cycle after the antecedent.
`define OCCB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/occb_pkg.sv
package occb_pkg;

  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned CellCodeW = 24;
  localparam int unsigned LevelW    = 4;

  localparam logic [2:0] REG_WORLD_MIN_X = 3'd0;
  localparam logic [2:0] REG_WORLD_MIN_Y = 3'd1;
  localparam logic [2:0] REG_WORLD_MIN_Z = 3'd2;
  localparam logic [2:0] REG_INV_CELL_X  = 3'd3;
  localparam logic [2:0] REG_INV_CELL_Y  = 3'd4;
  localparam logic [2:0] REG_INV_CELL_Z  = 3'd5;
  localparam logic [2:0] REG_MAX_CELL    = 3'd6;
  localparam logic [2:0] REG_TREE_LEVELS = 3'd7;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic [CellCodeW-1:0] cell_code;
    logic [LevelW-1:0]    cell_level;
  } cell_t;

  // Load enables of the two pipeline stages inside each axis unit.
  typedef struct packed {
    logic s1;
    logic s2;
  } adv_t;

endpackage

### rtl/octree_cell_of_box.sv
// Throughput: one item per cycle; four pipeline registers (input, difference,
// product, result) each move on when the stage after them is free.
// The six 32x32 multipliers sit alone between the difference and product stages.
// Reset clears the valid bits and sets the configuration registers to their default values.
module octree_cell_of_box
  import occb_pkg::*;
#(
  parameter int unsigned CoordBits = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  box_t                in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cell_t               out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned MortonW = 3 * CoordBits;
  localparam int unsigned ExtW    = (MortonW > CellCodeW) ? MortonW : CellCodeW;

  logic signed [31:0] world_min_x_q, world_min_y_q, world_min_z_q;
  logic [31:0]        inv_cell_x_q, inv_cell_y_q, inv_cell_z_q;
  logic [7:0]         max_cell_q;
  logic [3:0]         tree_levels_q;

  logic        v0_q, v1_q, v2_q, v3_q;
  logic        rdy0, rdy1, rdy2, rdy3;
  box_t        box_q;
  cell_t       out_q;
  adv_t        adv;

  logic [CoordBits-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [MortonW-1:0]   lo_code, hi_code, code_diff;
  logic [4:0]           groups;
  logic [4:0]           shift;
  logic [5:0]           shamt;
  logic [ExtW-1:0]      lo_ext, lo_shifted;
  logic [4:0]           level_wide;
  cell_t                res_d;
  logic [2:0]           reg_idx;
  logic                 cfg_wr;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_min_x_q <= '0;
      world_min_y_q <= '0;
      world_min_z_q <= '0;
      inv_cell_x_q  <= 32'd65536;
      inv_cell_y_q  <= 32'd65536;
      inv_cell_z_q  <= 32'd65536;
      max_cell_q    <= 8'd255;
      tree_levels_q <= 4'd8;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WORLD_MIN_X: world_min_x_q <= pwdata;
        REG_WORLD_MIN_Y: world_min_y_q <= pwdata;
        REG_WORLD_MIN_Z: world_min_z_q <= pwdata;
        REG_INV_CELL_X:  inv_cell_x_q  <= pwdata;
        REG_INV_CELL_Y:  inv_cell_y_q  <= pwdata;
        REG_INV_CELL_Z:  inv_cell_z_q  <= pwdata;
        REG_MAX_CELL:    max_cell_q    <= pwdata[7:0];
        REG_TREE_LEVELS: tree_levels_q <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WORLD_MIN_X: prdata = world_min_x_q;
      REG_WORLD_MIN_Y: prdata = world_min_y_q;
      REG_WORLD_MIN_Z: prdata = world_min_z_q;
      REG_INV_CELL_X:  prdata = inv_cell_x_q;
      REG_INV_CELL_Y:  prdata = inv_cell_y_q;
      REG_INV_CELL_Z:  prdata = inv_cell_z_q;
      REG_MAX_CELL:    prdata = {24'd0, max_cell_q};
      REG_TREE_LEVELS: prdata = {28'd0, tree_levels_q};
    endcase
  end

  // Pipeline flow control: a stage loads when it is empty or its item moves on.
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;
  assign adv.s1     = rdy1;
  assign adv.s2     = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      box_q <= in_item_i;
    end
    if (rdy3 && v2_q) begin
      out_q <= res_d;
    end
  end

  occb_axis #(.CoordBits(CoordBits)) u_lo_x (
    .clk_i, .pos_i(box_q.box_min_x), .origin_i(world_min_x_q), .inv_i(inv_cell_x_q),
    .max_cell_i(max_cell_q), .adv_i(adv), .idx_o(lo_x)
  );
  occb_axis #(.CoordBits(CoordBits)) u_lo_y (
    .clk_i, .pos_i(box_q.box_min_y), .origin_i(world_min_y_q), .inv_i(inv_cell_y_q),
    .max_cell_i(max_cell_q), .adv_i(adv), .idx_o(lo_y)
  );
  occb_axis #(.CoordBits(CoordBits)) u_lo_z (
    .clk_i, .pos_i(box_q.box_min_z), .origin_i(world_min_z_q), .inv_i(inv_cell_z_q),
    .max_cell_i(max_cell_q), .adv_i(adv), .idx_o(lo_z)
  );
  occb_axis #(.CoordBits(CoordBits)) u_hi_x (
    .clk_i, .pos_i(box_q.box_max_x), .origin_i(world_min_x_q), .inv_i(inv_cell_x_q),
    .max_cell_i(max_cell_q), .adv_i(adv), .idx_o(hi_x)
  );
  occb_axis #(.CoordBits(CoordBits)) u_hi_y (
    .clk_i, .pos_i(box_q.box_max_y), .origin_i(world_min_y_q), .inv_i(inv_cell_y_q),
    .max_cell_i(max_cell_q), .adv_i(adv), .idx_o(hi_y)
  );
  occb_axis #(.CoordBits(CoordBits)) u_hi_z (
    .clk_i, .pos_i(box_q.box_max_z), .origin_i(world_min_z_q), .inv_i(inv_cell_z_q),
    .max_cell_i(max_cell_q), .adv_i(adv), .idx_o(hi_z)
  );

  // Morton interleave, highest differing group, and the shift to that level.
  always_comb begin
    lo_code = '0;
    hi_code = '0;
    groups  = '0;
    for (int b = 0; b < CoordBits; b++) begin
      lo_code[3*b]   = lo_x[b];
      lo_code[3*b+1] = lo_y[b];
      lo_code[3*b+2] = lo_z[b];
      hi_code[3*b]   = hi_x[b];
      hi_code[3*b+1] = hi_y[b];
      hi_code[3*b+2] = hi_z[b];
    end
    code_diff = lo_code ^ hi_code;
    for (int g = 0; g < CoordBits; g++) begin
      if (|code_diff[3*g +: 3]) begin
        groups = 5'(g + 1);
      end
    end
    shift      = (groups > {1'b0, tree_levels_q}) ? {1'b0, tree_levels_q} : groups;
    shamt      = {1'b0, shift} + {shift, 1'b0};
    lo_ext     = ExtW'(lo_code);
    lo_shifted = lo_ext >> shamt;
    level_wide = {1'b0, tree_levels_q} - shift;
    res_d.cell_code  = lo_shifted[CellCodeW-1:0];
    res_d.cell_level = level_wide[LevelW-1:0];
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = out_q;

endmodule

### rtl/occb_axis.sv
module occb_axis
  import occb_pkg::*;
#(
  parameter int unsigned CoordBits
) (
  input  logic                 clk_i,
  input  logic signed [31:0]   pos_i,
  input  logic signed [31:0]   origin_i,
  input  logic [31:0]          inv_i,
  input  logic [7:0]           max_cell_i,
  input  adv_t                 adv_i,
  output logic [CoordBits-1:0] idx_o
);

  localparam logic [31:0] Lim = 32'((64'd1 << CoordBits) - 64'd1);

  logic [32:0] diff;
  logic        diff_pos;
  logic [31:0] mag_d, mag_q;
  logic [63:0] prod;
  logic [31:0] hi_d, hi_q;
  logic [31:0] max_ext;
  logic [31:0] sat1;
  logic [31:0] sat2;

  assign diff     = {pos_i[31], pos_i} - {origin_i[31], origin_i};
  assign diff_pos = !diff[32] && (|diff[31:0]);
  assign mag_d    = diff_pos ? diff[31:0] : '0;

  assign prod = {32'd0, mag_q} * {32'd0, inv_i};
  assign hi_d = prod[63:32];

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      mag_q <= mag_d;
    end
    if (adv_i.s2) begin
      hi_q <= hi_d;
    end
  end

  assign max_ext = {24'd0, max_cell_i};
  assign sat1    = (hi_q > max_ext) ? max_ext : hi_q;
  assign sat2    = (sat1 > Lim) ? Lim : sat1;
  assign idx_o   = sat2[CoordBits-1:0];

endmodule

### rtl/occb_checker.sv
`include "assert_macros.svh"

module occb_checker
  import occb_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_stall_o,
  input logic  out_valid_o,
  input logic  out_stall_i,
  input cell_t out_item_o,
  input logic  pready
);

  `OCCB_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `OCCB_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_item_o))
  `OCCB_ASSERT_IMP(a_no_stall_free, !out_stall_i, !in_stall_o && pready)
  `OCCB_ASSERT_NXT(a_latency, in_valid_i && !in_stall_o ##1 !out_stall_i [*3], out_valid_o)

endmodule

bind octree_cell_of_box occb_checker u_occb_checker (.*);

### test/octree_cell_checker.sv
module octree_cell_checker
  import occb_pkg::*;
#(
  parameter int unsigned CoordBits = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  box_t                in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cell_t               out_item_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned CodeW = 3 * CoordBits;

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [31:0]        inv_x, inv_y, inv_z;
  logic [7:0]         max_cell;
  logic [3:0]         levels;

  cell_t expected_cells[$];
  cell_t want;

  function automatic logic [CoordBits-1:0] axis_cell(logic signed [31:0] pos,
                                                     logic signed [31:0] origin,
                                                     logic [31:0] inv);
    logic [32:0] d;
    logic [63:0] prod;
    logic [31:0] c;
    logic [31:0] lim;
    lim = (32'd1 << CoordBits) - 32'd1;
    d = {pos[31], pos} - {origin[31], origin};
    if (d[32] || d == '0) begin
      return '0;
    end
    prod = {32'b0, d[31:0]} * {32'b0, inv};
    c = prod[63:32];
    if (c > {24'b0, max_cell}) begin
      c = {24'b0, max_cell};
    end
    if (c > lim) begin
      c = lim;
    end
    return c[CoordBits-1:0];
  endfunction

  function automatic logic [CodeW-1:0] interleave(logic [CoordBits-1:0] cx,
                                                  logic [CoordBits-1:0] cy,
                                                  logic [CoordBits-1:0] cz);
    logic [CodeW-1:0] code;
    code = '0;
    for (int b = 0; b < CoordBits; b++) begin
      code[3*b]   = cx[b];
      code[3*b+1] = cy[b];
      code[3*b+2] = cz[b];
    end
    return code;
  endfunction

  function automatic cell_t predict_cell(box_t box);
    logic [CodeW-1:0] lo_code;
    logic [CodeW-1:0] hi_code;
    logic [CodeW-1:0] diff;
    logic [CodeW-1:0] shifted;
    int               groups;
    int               lvl;
    int               shift;
    cell_t            res;
    lo_code = interleave(axis_cell(box.box_min_x, origin_x, inv_x),
                         axis_cell(box.box_min_y, origin_y, inv_y),
                         axis_cell(box.box_min_z, origin_z, inv_z));
    hi_code = interleave(axis_cell(box.box_max_x, origin_x, inv_x),
                         axis_cell(box.box_max_y, origin_y, inv_y),
                         axis_cell(box.box_max_z, origin_z, inv_z));
    diff = lo_code ^ hi_code;
    groups = 0;
    for (int g = 0; g < CoordBits; g++) begin
      if (diff[3*g +: 3] != 3'b000) begin
        groups = g + 1;
      end
    end
    lvl = int'(levels) - groups;
    if (lvl < 0) begin
      lvl = 0;
    end
    shift = int'(levels) - lvl;
    shifted = lo_code >> (3 * shift);
    res.cell_code  = CellCodeW'(shifted);
    res.cell_level = LevelW'(lvl);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x = '0;
      origin_y = '0;
      origin_z = '0;
      inv_x = 32'd65536;
      inv_y = 32'd65536;
      inv_z = 32'd65536;
      max_cell = 8'd255;
      levels = 4'd8;
      expected_cells.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected result: code %h level %0d", $time,
                   out_item_i.cell_code, out_item_i.cell_level);
          fail_count_o++;
        end else begin
          want = expected_cells.pop_front();
          if (out_item_i.cell_code !== want.cell_code) begin
            $display("%0t: cell_code mismatch: expected %h actual %h", $time,
                     want.cell_code, out_item_i.cell_code);
            fail_count_o++;
          end
          if (out_item_i.cell_level !== want.cell_level) begin
            $display("%0t: cell_level mismatch: expected %0d actual %0d", $time,
                     want.cell_level, out_item_i.cell_level);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_cells.push_back(predict_cell(in_item_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[CfgAddrW-1:2])
          REG_WORLD_MIN_X: origin_x = pwdata_i;
          REG_WORLD_MIN_Y: origin_y = pwdata_i;
          REG_WORLD_MIN_Z: origin_z = pwdata_i;
          REG_INV_CELL_X:  inv_x = pwdata_i;
          REG_INV_CELL_Y:  inv_y = pwdata_i;
          REG_INV_CELL_Z:  inv_z = pwdata_i;
          REG_MAX_CELL:    max_cell = pwdata_i[7:0];
          REG_TREE_LEVELS: levels = pwdata_i[3:0];
          default: ;
        endcase
      end
      pending_o = expected_cells.size();
    end
  end

endmodule

### test/tb.sv
module tb;
  import occb_pkg::*;

  localparam int unsigned Limit = 400000;
  localparam longint I32Max = 64'sd2147483647;
  localparam longint I32Min = -64'sd2147483648;
  localparam longint Span32 = 64'sd4294967296;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  box_t                in_item;
  logic                out_valid;
  logic                out_stall;
  cell_t               out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  bit          burst;
  longint      cfg_org[3];
  longint      cfg_inv[3];

  always #5 clk = ~clk;

  octree_cell_of_box dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  octree_cell_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == Limit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int r;
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      out_stall <= 1'b0;
      if (r < 15) begin
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_stall <= 1'b1;
      if (r >= 88) begin
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > I32Max) begin
      return 32'h7fff_ffff;
    end
    if (v < I32Min) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic longint cell_span(int axis);
    longint cs;
    cs = (cfg_inv[axis] == 0) ? Span32 : Span32 / cfg_inv[axis];
    return (cs < 1) ? 64'sd1 : cs;
  endfunction

  function automatic box_t mk_box(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                  logic [31:0] xx, logic [31:0] xy, logic [31:0] xz);
    box_t b;
    b.box_min_x = nx;
    b.box_min_y = ny;
    b.box_min_z = nz;
    b.box_max_x = xx;
    b.box_max_y = xy;
    b.box_max_z = xz;
    return b;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_box(box_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_box();
    logic [31:0] lo[3];
    logic [31:0] hi[3];
    logic [31:0] tmp;
    longint      cs;
    longint      ext;
    int          r;
    r = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) begin
      if (r < 20) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        cs = cell_span(a);
        lo[a] = clip32(cfg_org[a] + (longint'($urandom) % (cs * 260)) - 2 * cs);
        ext = longint'($urandom) % ((cs << $urandom_range(0, 8)) + 1);
        hi[a] = clip32(longint'($signed(lo[a])) + ext);
        if (r >= 90) begin
          tmp = lo[a];
          lo[a] = hi[a];
          hi[a] = tmp;
        end
      end
    end
    send_box(mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                              logic [7:0] maxc, logic [3:0] lvls);
    in_valid <= 1'b0;
    wait_idle();
    apb_write(REG_WORLD_MIN_X, ox);
    apb_write(REG_WORLD_MIN_Y, oy);
    apb_write(REG_WORLD_MIN_Z, oz);
    apb_write(REG_INV_CELL_X, ix);
    apb_write(REG_INV_CELL_Y, iy);
    apb_write(REG_INV_CELL_Z, iz);
    apb_write(REG_MAX_CELL, {24'b0, maxc});
    apb_write(REG_TREE_LEVELS, {28'b0, lvls});
    cfg_org[0] = longint'($signed(ox));
    cfg_org[1] = longint'($signed(oy));
    cfg_org[2] = longint'($signed(oz));
    cfg_inv[0] = longint'(ix);
    cfg_inv[1] = longint'(iy);
    cfg_inv[2] = longint'(iz);
  endtask

  function automatic logic [31:0] pick_origin();
    if ($urandom_range(0, 1) == 0) begin
      return $urandom;
    end
    return 32'($urandom_range(0, 2000000)) - 32'd1000000;
  endfunction

  function automatic logic [31:0] pick_inv();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return 32'd65536;
    end
    if (r < 80) begin
      return 32'd1 << $urandom_range(8, 24);
    end
    return $urandom;
  endfunction

  task automatic random_config();
    logic [7:0] maxc;
    logic [3:0] lvls;
    maxc = ($urandom_range(0, 9) < 4) ? 8'd255 : 8'($urandom_range(0, 255));
    lvls = ($urandom_range(0, 9) < 3) ? 4'd8 : 4'($urandom_range(0, 8));
    write_config(pick_origin(), pick_origin(), pick_origin(),
                 pick_inv(), pick_inv(), pick_inv(), maxc, lvls);
  endtask

  initial begin
    rst_n   <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    burst   = 1'b0;
    for (int a = 0; a < 3; a++) begin
      cfg_org[a] = 0;
      cfg_inv[a] = 65536;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_box(mk_box(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_box(mk_box(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
    send_box(mk_box(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'h0));
    send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(mk_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_box(mk_box(32'h38000, 32'h24000, 32'h7e666, 32'h3e666, 32'h28000, 32'h7fd70));
    send_box(mk_box(32'h80000, 32'h80000, 32'h80000, 32'hf0000, 32'hf0000, 32'hf0000));
    send_box(mk_box(32'hff0000, 32'hff0000, 32'hff0000,
                    32'h1000000, 32'h1000000, 32'h1000000));
    send_box(mk_box(32'hfff0_0000, 32'h4000_0000, 32'h0050_0000,
                    32'h0001_8000, 32'h4000_0001, 32'h0052_0000));

    // Shallow tree, doubled resolution, origin at -10.
    write_config(32'hfff6_0000, 32'hfff6_0000, 32'hfff6_0000,
                 32'h20000, 32'h20000, 32'h20000, 8'd200, 4'd3);
    send_box(mk_box(32'hfff6_0000, 32'hfff6_0000, 32'hfff6_0000,
                    32'h0064_0000, 32'h0064_0000, 32'h0064_0000));
    send_box(mk_box(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    32'h0001_4000, 32'h0002_4000, 32'h0003_4000));
    send_box(mk_box(32'h0005_0000, 32'hfff0_0000, 32'h0050_0000,
                    32'h0070_0000, 32'hfff8_0000, 32'h0051_0000));

    write_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'd255, 4'd0);
    send_box(mk_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_box(mk_box(32'h8000_0001, 32'h8000_0100, 32'h8001_0000,
                    32'h8000_0001, 32'h8000_0100, 32'h8001_0000));
    send_box(mk_box(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));

    write_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h0, 32'h0, 32'h0, 8'd0, 4'd8);
    send_box(mk_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_box(mk_box(32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 32'h0, 32'h0));

    write_config(32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000, 8'd15, 4'd8);
    send_box(mk_box(32'h0003_0000, 32'h0009_0000, 32'h0020_0000,
                    32'h0004_0000, 32'h000a_0000, 32'h0030_0000));
    send_box(mk_box(32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
                    32'h0011_0000, 32'h0001_0000, 32'h0002_0000));

    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        write_config(32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000, 8'd255, 4'd8);
      end else begin
        random_config();
      end
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0) begin
          burst = ($urandom_range(0, 2) == 0);
        end
        send_random_box();
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
